### sv/bbf_pkg.sv
// Package for the B-spline basis evaluator: widths, item types, codes and helpers.
`default_nettype none

package bbf_pkg;

  // Fixed field widths of the item formats.
  localparam int FRAC_BITS   = 16;
  localparam int KNOT_W      = 32;
  localparam int VAL_W       = FRAC_BITS + 1;
  localparam int DIFF_W      = KNOT_W + 2;
  localparam int IDX_W       = 5;
  localparam int DEG_W       = 3;
  localparam int TOL_W       = 16;
  localparam int OFF_W       = 4;
  localparam int ADDR_FULL_W = 9;
  localparam int SUM_W       = 7;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [VAL_W-1:0] ONE_VAL  = VAL_W'(1) << FRAC_BITS;
  localparam logic [VAL_W-1:0] ZERO_VAL = '0;

  // Configuration register indexes and reset values.
  localparam logic [CFG_ADDR_W-1:0] CFG_DEGREE    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_LAST_KNOT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE = 2'd2;

  localparam logic [DEG_W-1:0] DEGREE_RST    = 3'd3;
  localparam logic [IDX_W-1:0] LAST_KNOT_RST = 5'd7;
  localparam logic [TOL_W-1:0] TOLERANCE_RST = 16'd1;

  // Item function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_EVAL  = 1'b1;

  typedef struct packed {
    logic              func;
    logic [IDX_W-1:0]  knot_slot;
    logic [KNOT_W-1:0] knot_value;
    logic [KNOT_W-1:0] param_u;
    logic [IDX_W-1:0]  basis_index;
  } bbf_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] basis_value;
    logic             index_error;
  } bbf_out_t;

  // Datapath operations issued by the controller.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_END0,
    OP_ENDM,
    OP_SPANLO,
    OP_SPANHI,
    OP_BASE_FIRST,
    OP_BASE_NEXT,
    OP_ROT,
    OP_POP,
    OP_POP_ROT,
    OP_DIV_UA,
    OP_DIV_BU,
    OP_SAVED_Q,
    OP_RIGHT_Q,
    OP_PUSH_SUM,
    OP_EMIT
  } op_t;

  // Knot address bases.
  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_LAST,
    BASE_SPAN
  } base_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHK,
    S_E0_RD,
    S_E0_USE,
    S_EM_RD,
    S_EM_USE,
    S_LO_RD,
    S_LO_USE,
    S_HI_RD,
    S_HI_USE,
    S_SPAN,
    S_BASE_RD,
    S_BASE_USE,
    S_ALIGN,
    S_LV_RDA,
    S_LV_RDB,
    S_LV_CAPB,
    S_LV_DIV,
    S_LV_WAIT,
    S_T_RDA,
    S_T_RDB,
    S_T_CAPB,
    S_T_DIVR,
    S_T_WAITR,
    S_T_PUSH,
    S_T_DIVL,
    S_T_WAITL,
    S_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_SAT,
    DIV_ITER,
    DIV_DONE
  } div_state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic             knot_wr;
    op_t              op;
    logic             rd_en;
    base_t            rd_base;
    logic [OFF_W-1:0] rd_off;
    logic             cap_a;
    logic             cap_b;
  } bbf_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic [OFF_W-1:0] p;
    logic             err;
    logic             skip;
    logic             div_done;
  } bbf_stat_t;

  // Exact signed difference of two unsigned knot-format values.
  function automatic logic signed [DIFF_W-1:0] knot_diff(input logic [KNOT_W-1:0] a,
                                                         input logic [KNOT_W-1:0] b);
    knot_diff = $signed({2'b00, a}) - $signed({2'b00, b});
  endfunction

endpackage

`default_nettype wire

### sv/bbf_div.sv
// Shared serial unit for clamp((num * n) / den), one quotient bit per cycle.
`default_nettype none

module bbf_div
  import bbf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] num,
  input  logic signed [DIFF_W-1:0] den,
  input  logic [VAL_W-1:0]         nval,
  output logic                     done,
  output logic [VAL_W-1:0]         quo
);

  localparam int PW   = KNOT_W + VAL_W;
  localparam int CNTW = $clog2(VAL_W + 1);

  div_state_t         state;
  div_state_t         state_next;
  logic [PW-1:0]      prod;
  logic [KNOT_W-1:0]  den_q;
  logic [KNOT_W-1:0]  rem;
  logic [VAL_W-1:0]   low;
  logic [CNTW-1:0]    cnt;
  logic               trivial;
  logic               sat;
  logic [KNOT_W:0]    rem_sh;
  logic               ge;
  logic [KNOT_W:0]    rem_sub;
  logic [VAL_W-1:0]   q_final;
  logic               last;

  // A non-positive numerator or divisor, or a zero term, needs no division.
  assign trivial = (num <= 0) || (den <= 0) || (nval == ZERO_VAL);
  assign sat     = prod[PW-1:VAL_W] >= den_q;
  assign rem_sh  = {rem, low[VAL_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign q_final = {low[VAL_W-2:0], ge};
  assign last    = (cnt == CNTW'(VAL_W - 1));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      DIV_IDLE: if (start) state_next = trivial ? DIV_DONE : DIV_SAT;
      DIV_SAT:  state_next = sat ? DIV_DONE : DIV_ITER;
      DIV_ITER: if (last) state_next = DIV_DONE;
      DIV_DONE: state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done = (state == DIV_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Product, then restoring division of its low bits under the high part.
  always_ff @(posedge clk) begin
    case (state)
      DIV_IDLE: begin
        if (start) begin
          prod  <= PW'(num[KNOT_W-1:0]) * PW'(nval);
          den_q <= den[KNOT_W-1:0];
          quo   <= ZERO_VAL;
        end
      end
      DIV_SAT: begin
        rem <= prod[PW-1:VAL_W];
        low <= prod[VAL_W-1:0];
        cnt <= '0;
        if (sat) begin
          quo <= ONE_VAL;
        end
      end
      DIV_ITER: begin
        rem <= ge ? rem_sub[KNOT_W-1:0] : rem_sh[KNOT_W-1:0];
        low <= q_final;
        cnt <= cnt + CNTW'(1);
        if (last) begin
          quo <= (q_final > ONE_VAL) ? ONE_VAL : q_final;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### sv/bbf_dp.sv
// Datapath: configuration registers, knot memory, span tests, term queue and divider.
`default_nettype none

module bbf_dp
  import bbf_pkg::*;
#(
  parameter int MAX_KNOTS  = 32,
  parameter int MAX_DEGREE = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  bbf_in_t               item,
  input  bbf_cmd_t              cmd,
  output bbf_stat_t             stat,
  output logic                  done,
  output bbf_out_t              result
);

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int L  = MAX_DEGREE + 1;

  logic [DEG_W-1:0]         degree;
  logic [IDX_W-1:0]         last_knot;
  logic [TOL_W-1:0]         tolerance;
  logic [KNOT_W-1:0]        knot_mem [MAX_KNOTS];
  logic [KNOT_W-1:0]        kq_raw;
  logic                     kq_zero;
  logic [KNOT_W-1:0]        kq;
  logic [ADDR_FULL_W-1:0]   wr_full;
  logic [ADDR_FULL_W-1:0]   rd_full;
  logic [KNOT_W-1:0]        u_q;
  logic [IDX_W-1:0]         i_q;
  logic [OFF_W-1:0]         p_q;
  logic [OFF_W-1:0]         p_sel;
  logic                     err_q;
  logic                     err_next;
  logic                     flag_end;
  logic                     flag_out;
  logic                     geq_prev;
  logic [KNOT_W-1:0]        ka;
  logic [KNOT_W-1:0]        kb;
  logic [VAL_W-1:0]         n_cur;
  logic [VAL_W-1:0]         saved;
  logic [VAL_W-1:0]         right;
  logic [VAL_W-1:0]         q [L];
  logic                     rot_en;
  logic [VAL_W-1:0]         rot_val;
  logic signed [DIFF_W-1:0] eps_s;
  logic signed [DIFF_W-1:0] d_uk;
  logic signed [DIFF_W-1:0] d_ku;
  logic                     t_eq;
  logic                     t_less;
  logic                     t_geq;
  logic [VAL_W:0]           sum;
  logic [VAL_W-1:0]         sum_cl;
  logic                     div_start;
  logic signed [DIFF_W-1:0] div_num;
  logic signed [DIFF_W-1:0] div_den;
  logic                     div_done;
  logic [VAL_W-1:0]         div_quo;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      degree    <= DEGREE_RST;
      last_knot <= LAST_KNOT_RST;
      tolerance <= TOLERANCE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_DEGREE:    degree    <= cfg_data[DEG_W-1:0];
        CFG_LAST_KNOT: last_knot <= cfg_data[IDX_W-1:0];
        CFG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Knot address: slots beyond the table are dropped on write and read as zero.
  assign wr_full = ADDR_FULL_W'(item.knot_slot);
  always_comb begin
    case (cmd.rd_base)
      BASE_ZERO: rd_full = '0;
      BASE_LAST: rd_full = ADDR_FULL_W'(last_knot);
      BASE_SPAN: rd_full = ADDR_FULL_W'(i_q) + ADDR_FULL_W'(cmd.rd_off);
      default:   rd_full = '0;
    endcase
  end

  // Knot memory with a registered read port.
  always_ff @(posedge clk) begin
    if (cmd.knot_wr && (32'(wr_full) < 32'(MAX_KNOTS))) begin
      knot_mem[wr_full[AW-1:0]] <= item.knot_value;
    end
    if (cmd.rd_en) begin
      kq_raw  <= knot_mem[rd_full[AW-1:0]];
      kq_zero <= !(32'(rd_full) < 32'(MAX_KNOTS));
    end
  end
  assign kq = kq_zero ? '0 : kq_raw;

  // Tolerant comparisons of u against the knot just read.
  assign eps_s  = $signed({{(DIFF_W - TOL_W){1'b0}}, tolerance});
  assign d_uk   = knot_diff(u_q, kq);
  assign d_ku   = knot_diff(kq, u_q);
  assign t_eq   = (d_uk < eps_s) && (d_uk > -eps_s);
  assign t_less = d_ku > eps_s;
  assign t_geq  = d_uk > -eps_s;

  // Degree clamp and index check for a new item.
  assign p_sel = (32'(degree) > 32'(MAX_DEGREE)) ? OFF_W'(MAX_DEGREE) : OFF_W'(degree);
  assign err_next = (SUM_W'(item.basis_index) + SUM_W'(p_sel) + SUM_W'(1)) > SUM_W'(last_knot);

  // Sum of the carried left part and the new right part.
  assign sum    = {1'b0, saved} + {1'b0, right};
  assign sum_cl = (sum > {1'b0, ONE_VAL}) ? ONE_VAL : sum[VAL_W-1:0];

  // Term queue moves: a push enters at the tail, a rotation recirculates the head.
  always_comb begin
    rot_en  = 1'b0;
    rot_val = q[0];
    case (cmd.op)
      OP_ROT, OP_POP_ROT: rot_en = 1'b1;
      OP_BASE_NEXT: begin
        rot_en  = 1'b1;
        rot_val = (geq_prev && t_less) ? ONE_VAL : ZERO_VAL;
      end
      OP_PUSH_SUM: begin
        rot_en  = 1'b1;
        rot_val = sum_cl;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rot_en) begin
      for (int x = 0; x < L - 1; x++) begin
        q[x] <= q[x + 1];
      end
      q[L-1] <= rot_val;
    end
  end

  // Operand registers and flags.
  always_ff @(posedge clk) begin
    if (cmd.cap_a) ka <= kq;
    if (cmd.cap_b) kb <= kq;
    case (cmd.op)
      OP_LOAD: begin
        u_q      <= item.param_u;
        i_q      <= item.basis_index;
        p_q      <= p_sel;
        err_q    <= err_next;
        flag_end <= 1'b0;
        flag_out <= 1'b0;
      end
      OP_END0:       flag_end <= flag_end | ((i_q == '0) && t_eq);
      OP_ENDM: begin
        flag_end <= flag_end |
                    (((SUM_W'(i_q) + SUM_W'(p_q) + SUM_W'(1)) == SUM_W'(last_knot)) && t_eq);
      end
      OP_SPANLO:     flag_out <= flag_out | t_less;
      OP_SPANHI:     flag_out <= flag_out | t_geq;
      OP_BASE_FIRST: geq_prev <= t_geq;
      OP_BASE_NEXT:  geq_prev <= t_geq;
      OP_POP, OP_POP_ROT: n_cur <= q[0];
      OP_SAVED_Q:    saved <= div_quo;
      OP_RIGHT_Q:    right <= div_quo;
      default: ;
    endcase
  end

  // Result register and its one-cycle strobe.
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      result.index_error <= err_q;
      if (err_q || (!flag_end && flag_out)) begin
        result.basis_value <= ZERO_VAL;
      end else if (flag_end) begin
        result.basis_value <= ONE_VAL;
      end else begin
        result.basis_value <= q[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (cmd.op == OP_EMIT);
    end
  end

  // Divider operands: numerator u - lo or hi - u, divisor hi - lo.
  assign div_start = (cmd.op == OP_DIV_UA) || (cmd.op == OP_DIV_BU);
  assign div_num   = (cmd.op == OP_DIV_BU) ? knot_diff(kb, u_q) : knot_diff(u_q, ka);
  assign div_den   = knot_diff(kb, ka);

  bbf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .nval  (n_cur),
    .done  (div_done),
    .quo   (div_quo)
  );

  assign stat.p        = p_q;
  assign stat.err      = err_q;
  assign stat.skip     = flag_end | flag_out;
  assign stat.div_done = div_done;

endmodule

`default_nettype wire

### sv/bbf_ctrl.sv
// Controller: sequences span checks, degree-zero terms and the recurrence levels.
`default_nettype none

module bbf_ctrl
  import bbf_pkg::*;
#(
  parameter int MAX_DEGREE = 5
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      func,
  input  bbf_stat_t stat,
  output logic      busy,
  output bbf_cmd_t  cmd
);

  localparam int CW = $clog2(MAX_DEGREE + 2);
  localparam int L  = MAX_DEGREE + 1;

  ctrl_state_t   state;
  ctrl_state_t   state_next;
  logic [CW-1:0] j;
  logic [CW-1:0] k;
  logic [CW-1:0] pad;
  logic [CW-1:0] p_c;
  logic          base_last;
  logic          term_last;

  assign p_c       = CW'(stat.p);
  assign base_last = (j == p_c + CW'(1));
  assign term_last = (j == p_c - k);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:     if (start && (func == FUNC_EVAL)) state_next = S_CHK;
      S_CHK:      state_next = stat.err ? S_EMIT : S_E0_RD;
      S_E0_RD:    state_next = S_E0_USE;
      S_E0_USE:   state_next = S_EM_RD;
      S_EM_RD:    state_next = S_EM_USE;
      S_EM_USE:   state_next = S_LO_RD;
      S_LO_RD:    state_next = S_LO_USE;
      S_LO_USE:   state_next = S_HI_RD;
      S_HI_RD:    state_next = S_HI_USE;
      S_HI_USE:   state_next = S_SPAN;
      S_SPAN:     state_next = stat.skip ? S_EMIT : S_BASE_RD;
      S_BASE_RD:  state_next = S_BASE_USE;
      S_BASE_USE: state_next = base_last ? S_ALIGN : S_BASE_RD;
      S_ALIGN: begin
        if (pad == '0) state_next = (k > p_c) ? S_EMIT : S_LV_RDA;
      end
      S_LV_RDA:   state_next = S_LV_RDB;
      S_LV_RDB:   state_next = S_LV_CAPB;
      S_LV_CAPB:  state_next = S_LV_DIV;
      S_LV_DIV:   state_next = S_LV_WAIT;
      S_LV_WAIT:  if (stat.div_done) state_next = S_T_RDA;
      S_T_RDA:    state_next = S_T_RDB;
      S_T_RDB:    state_next = S_T_CAPB;
      S_T_CAPB:   state_next = S_T_DIVR;
      S_T_DIVR:   state_next = S_T_WAITR;
      S_T_WAITR:  if (stat.div_done) state_next = S_T_PUSH;
      S_T_PUSH:   state_next = S_T_DIVL;
      S_T_DIVL:   state_next = S_T_WAITL;
      S_T_WAITL: begin
        if (stat.div_done) state_next = term_last ? S_ALIGN : S_T_RDA;
      end
      S_EMIT:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd         = '0;
    cmd.op      = OP_NONE;
    cmd.rd_base = BASE_SPAN;
    busy        = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.knot_wr = (func == FUNC_WRITE);
          cmd.op      = (func == FUNC_EVAL) ? OP_LOAD : OP_NONE;
        end
      end
      S_E0_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_base = BASE_ZERO;
      end
      S_E0_USE: cmd.op = OP_END0;
      S_EM_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_base = BASE_LAST;
      end
      S_EM_USE: cmd.op = OP_ENDM;
      S_LO_RD:  cmd.rd_en = 1'b1;
      S_LO_USE: cmd.op = OP_SPANLO;
      S_HI_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_W'(p_c + CW'(1));
      end
      S_HI_USE: cmd.op = OP_SPANHI;
      S_BASE_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_W'(j);
      end
      S_BASE_USE: cmd.op = (j == '0) ? OP_BASE_FIRST : OP_BASE_NEXT;
      S_ALIGN:    if (pad != '0) cmd.op = OP_ROT;
      S_LV_RDA:   cmd.rd_en = 1'b1;
      S_LV_RDB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_W'(k);
        cmd.cap_a  = 1'b1;
      end
      S_LV_CAPB: begin
        cmd.cap_b = 1'b1;
        cmd.op    = OP_POP_ROT;
      end
      S_LV_DIV:   cmd.op = OP_DIV_UA;
      S_LV_WAIT:  if (stat.div_done) cmd.op = OP_SAVED_Q;
      S_T_RDA: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_W'(j + CW'(1));
      end
      S_T_RDB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_off = OFF_W'(j + k + CW'(1));
        cmd.cap_a  = 1'b1;
      end
      S_T_CAPB: begin
        cmd.cap_b = 1'b1;
        cmd.op    = OP_POP;
      end
      S_T_DIVR:   cmd.op = OP_DIV_BU;
      S_T_WAITR:  if (stat.div_done) cmd.op = OP_RIGHT_Q;
      S_T_PUSH:   cmd.op = OP_PUSH_SUM;
      S_T_DIVL:   cmd.op = OP_DIV_UA;
      S_T_WAITL:  if (stat.div_done) cmd.op = OP_SAVED_Q;
      S_EMIT:     cmd.op = OP_EMIT;
      default: ;
    endcase
  end

  // State register and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      k     <= '0;
      pad   <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_SPAN: begin
          j <= '0;
          k <= CW'(1);
        end
        S_BASE_USE: begin
          if (base_last) begin
            pad <= CW'(L) - (p_c + CW'(1));
          end else begin
            j <= j + CW'(1);
          end
        end
        S_ALIGN: if (pad != '0) pad <= pad - CW'(1);
        S_LV_WAIT: if (stat.div_done) j <= '0;
        S_T_WAITL: begin
          if (stat.div_done) begin
            if (term_last) begin
              pad <= CW'(L) - (p_c - k + CW'(1));
              k   <= k + CW'(1);
            end else begin
              j <= j + CW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/bspline_basis_function_eval_core.sv
// Top level of the B-spline basis evaluator: controller, datapath and checks.
// An evaluation ends early on an index error, or when an end knot or the span test
// decides. Otherwise it runs checks and set-up, then p levels and p(p+1)/2 terms;
// a trivial division skips the iterations of the shared serial divider. One item at
// a time; the receiver cannot stall. Synchronous reset gives degree 3, last knot 7, tol 1.
`default_nettype none

module bspline_basis_function_eval_core
  import bbf_pkg::*;
#(
  parameter int MAX_KNOTS  = 32,
  parameter int MAX_DEGREE = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  bbf_in_t               item,
  output logic                  done,
  output bbf_out_t              result,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  bbf_cmd_t  cmd;
  bbf_stat_t stat;

  bbf_ctrl #(
    .MAX_DEGREE (MAX_DEGREE)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .func  (item.func),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bbf_dp #(
    .MAX_KNOTS  (MAX_KNOTS),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .stat     (stat),
    .done     (done),
    .result   (result)
  );

  // An accepted evaluation item keeps the block busy; a knot write does not.
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.func == FUNC_EVAL)) |=> busy)
    else $error("evaluation item accepted without going busy");

  assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.func == FUNC_WRITE)) |=> !busy && !done)
    else $error("knot write item started an evaluation");

  // A result is only shown once the item has finished.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while still busy");

  // Results stay in the unit range and an index error forces zero.
  assert property (@(posedge clk) disable iff (rst)
    done |-> (result.basis_value <= ONE_VAL) &&
             (!result.index_error || (result.basis_value == ZERO_VAL)))
    else $error("result out of range");

endmodule

`default_nettype wire

### bench/tb_bspline_basis_function_eval_core.sv
// Self-checking bench for the B-spline basis evaluator, with knot loads and evaluations.
`default_nettype none

module tb_bspline_basis_function_eval_core;
  import bbf_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  bbf_in_t               item;
  logic                  done;
  bbf_out_t              result;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;

  bspline_basis_function_eval_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  // Bench copy of the registers and the knot table.
  logic [DEG_W-1:0]  deg_q;
  logic [IDX_W-1:0]  last_q;
  logic [TOL_W-1:0]  tol_q;
  logic [KNOT_W-1:0] knot_mirror [32];

  bbf_in_t  pending_items [$];
  bbf_out_t expected_basis [$];
  int       idle_pct;
  int       mismatches;
  logic     item_taken;

  // Knot values as the generator last wrote them, used to aim parameters.
  logic [KNOT_W-1:0] gen_knots [32];

  localparam longint UNIT = longint'(1) << FRAC_BITS;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint knot_at(longint idx);
    if (idx < 0 || idx >= 32) return 0;
    return longint'(knot_mirror[idx]);
  endfunction

  function automatic bit near(longint a, longint b, longint eps);
    longint d;
    d = a - b;
    if (d < 0) d = -d;
    return d < eps;
  endfunction

  function automatic bit below(longint a, longint b, longint eps);
    return (b - a) > eps;
  endfunction

  function automatic bit at_or_above(longint a, longint b, longint eps);
    return (a - b) > -eps;
  endfunction

  function automatic longint clamp_unit(longint v);
    if (v < 0) return 0;
    if (v > UNIT) return UNIT;
    return v;
  endfunction

  function automatic longint ratio_term(longint num, longint n, longint den);
    if (den <= 0) return 0;
    return clamp_unit((num * n) / den);
  endfunction

  // Cox-de Boor recurrence over the degree-zero terms of span i..i+p.
  function automatic bbf_out_t predict_basis(logic [KNOT_W-1:0] u_raw, logic [IDX_W-1:0] idx);
    longint   u, i, p, m, eps, saved, lo, hi, right;
    longint   n [6];
    bbf_out_t r;
    u = longint'(u_raw);
    i = longint'(idx);
    p = (deg_q > 3'd5) ? 5 : longint'(deg_q);
    m = longint'(last_q);
    eps = longint'(tol_q);
    r = '0;
    if (i + p + 1 > m) begin
      r.index_error = 1'b1;
      return r;
    end
    if ((i == 0 && near(u, knot_at(0), eps)) || (i == m - p - 1 && near(u, knot_at(m), eps))) begin
      r.basis_value = ONE_VAL;
      return r;
    end
    if (below(u, knot_at(i), eps) || at_or_above(u, knot_at(i + p + 1), eps)) return r;
    for (int j = 0; j <= p; j++) begin
      n[j] = (at_or_above(u, knot_at(i + j), eps) && below(u, knot_at(i + j + 1), eps)) ?
             UNIT : 0;
    end
    for (int k = 1; k <= p; k++) begin
      saved = (n[0] == 0) ? 0 : ratio_term(u - knot_at(i), n[0], knot_at(i + k) - knot_at(i));
      for (int j = 0; j < p - k + 1; j++) begin
        lo = knot_at(i + j + 1);
        hi = knot_at(i + j + k + 1);
        if (n[j + 1] == 0) begin
          n[j] = saved;
          saved = 0;
        end else begin
          right = ratio_term(hi - u, n[j + 1], hi - lo);
          n[j] = clamp_unit(saved + right);
          saved = ratio_term(u - lo, n[j + 1], hi - lo);
        end
      end
    end
    r.basis_value = VAL_W'(clamp_unit(n[0]));
    return r;
  endfunction

  // Driver: a new item goes out once the previous one has been taken.
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || item_taken) begin
      if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
        start <= 1'b1;
        item  <= pending_items.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on acceptance, check each strobed result.
  always @(posedge clk) begin
    if (rst) begin
      item_taken <= 1'b0;
    end else begin
      item_taken <= start && !busy;
      if (done) begin
        if (expected_basis.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", result);
        end else begin
          bbf_out_t want;
          want = expected_basis.pop_front();
          if (result.basis_value !== want.basis_value ||
              result.index_error !== want.index_error) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected value %h err %b, got value %h err %b",
                       want.basis_value, want.index_error,
                       result.basis_value, result.index_error);
          end
        end
      end
      if (start && !busy) begin
        if (item.func == FUNC_WRITE) knot_mirror[item.knot_slot] <= item.knot_value;
        else expected_basis.insert(expected_basis.size(),
                                   predict_basis(item.param_u, item.basis_index));
      end
    end
  end

  task automatic push_write(logic [IDX_W-1:0] slot, logic [KNOT_W-1:0] val);
    bbf_in_t it;
    it = {$urandom, $urandom};
    it.func = FUNC_WRITE;
    it.knot_slot = slot;
    it.knot_value = val;
    gen_knots[slot] = val;
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic push_eval(logic [KNOT_W-1:0] u, logic [IDX_W-1:0] idx);
    bbf_in_t it;
    it = {$urandom, $urandom};
    it.func = FUNC_EVAL;
    it.param_u = u;
    it.basis_index = idx;
    pending_items.insert(pending_items.size(), it);
  endtask

  // Loads all 32 knots: ascending with random steps, repeats, near the top, or disordered.
  task automatic load_knots(int shape);
    logic [KNOT_W-1:0] v;
    int unsigned       stride;
    v = (shape == 2) ? 32'hFFFF_0000 + $urandom_range(255) : $urandom_range(32'h0004_0000);
    stride = (shape == 2) ? 32'h7F0 : $urandom_range(32'h0003_0000, 1);
    for (int s = 0; s < 32; s++) begin
      if (shape == 3) begin
        push_write(s, $urandom);
      end else begin
        push_write(s, v);
        if (shape != 1 || $urandom_range(2) != 0) v = v + $urandom_range(stride);
      end
    end
  endtask

  // Parameters aimed at knots, inside spans, or anywhere.
  task automatic random_eval();
    logic [IDX_W-1:0]  idx;
    logic [KNOT_W-1:0] u;
    int                pick;
    int                hi_slot;
    idx = $urandom_range(31);
    hi_slot = (int'(idx) + int'(deg_q) + 1 > 31) ? 31 : int'(idx) + int'(deg_q) + 1;
    pick = $urandom_range(9);
    case (pick)
      0: begin
        u = $urandom;
      end
      1, 2: begin
        u = gen_knots[$urandom_range(31)] + $urandom_range(4) - 2;
      end
      3: begin
        u = gen_knots[last_q];
        idx = (int'(last_q) > int'(deg_q)) ? last_q - deg_q - 1 : 0;
      end
      default: begin
        u = gen_knots[idx] + $urandom_range(
            (gen_knots[hi_slot] > gen_knots[idx]) ? gen_knots[hi_slot] - gen_knots[idx] : 3);
      end
    endcase
    push_eval(u, idx);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    if (addr == CFG_DEGREE) deg_q = data[DEG_W-1:0];
    else if (addr == CFG_LAST_KNOT) last_q = data[IDX_W-1:0];
    else if (addr == CFG_TOLERANCE) tol_q = data[TOL_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every item is out and every result in, then lets a write item settle.
  task automatic drain();
    while (pending_items.size() > 0 || start || expected_basis.size() > 0) @(posedge clk);
    repeat (1000) @(posedge clk);
  endtask

  initial begin
    int deg_set [8];
    int last_set [8];
    int tol_set [8];
    deg_set  = '{3, 1, 5, 2, 0, 7, 4, 6};
    last_set = '{7, 31, 31, 12, 9, 20, 31, 1};
    tol_set  = '{1, 0, 65535, 3, 1, 100, 0, 40};
    rst = 1'b1;
    start = 1'b0;
    item = '0;
    cfg_we = 1'b0;
    cfg_addr = CFG_DEGREE;
    cfg_data = '0;
    idle_pct = 0;
    mismatches = 0;
    deg_q = DEGREE_RST;
    last_q = LAST_KNOT_RST;
    tol_q = TOLERANCE_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: integer knots, end knots, outside span, extremes and index error.
    for (int s = 0; s < 32; s++) push_write(s, (s < 3) ? 32'd0 : (s - 2) << FRAC_BITS);
    push_eval(32'd0, 5'd0);
    push_eval(32'h0005_0000, 5'd3);
    push_eval(32'h0001_8000, 5'd0);
    push_eval(32'h0002_4000, 5'd1);
    push_eval(32'h0000_0000, 5'd4);
    push_eval(32'hFFFF_FFFF, 5'd2);
    push_eval(32'h0002_0000, 5'd2);
    push_eval(32'h0001_0001, 5'd1);
    push_eval(32'h0003_0000, 5'd31);
    push_eval(32'h0003_0000, 5'd4);
    drain();

    // Random phases over several register settings and idle rates.
    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_DEGREE, deg_set[ph]);
        write_reg(CFG_LAST_KNOT, last_set[ph]);
        write_reg(CFG_TOLERANCE, tol_set[ph]);
      end
      idle_pct = (ph % 4 == 1) ? 59 : (ph % 4 == 3) ? 33 : 0;
      for (int ld = 0; ld < 3; ld++) begin
        load_knots((ld + ph) % 4);
        for (int e = 0; e < 45; e++) random_eval();
      end
      drain();
    end

    if (mismatches == 0 && expected_basis.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire
